// ===== rtl/pwmosc_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmosc_pkg: shared types and constants of the smoothed PWM oscillator
// Widths of the smoothed state, fixed-point scaling, reset values and
// configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pwmosc_pkg;

   // Sample rate that sets the reset increment (100 Hz tone).
   localparam int SAMPLE_RATE = 44100;

   // Extra fraction bits carried by the smoothed values.
   localparam int FRAC_EXTRA = 16;

   // Field widths.
   localparam int TINC_W   = 31;
   localparam int TDUTY_W  = 17;
   localparam int COEFF_W  = 16;
   localparam int VOLUME_W = 15;
   localparam int SAMPLE_W = 16;
   localparam int PHASE_W  = 32;

   // Smoothed state widths: increment Q0.48, duty Q1.32.
   localparam int SMOOTH_W = 48;
   localparam int DUTY_W   = 33;

   // Product of a state difference and the coefficient.
   localparam int PROD_W = SMOOTH_W + COEFF_W;

   // Duty of one in Q1.16.
   localparam logic [TDUTY_W-1:0] DUTY_ONE = TDUTY_W'(65536);

   // Reset values of the state and the configuration registers.
   localparam logic [63:0] INC_RESET_WIDE =
      ((64'd100 << 48) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
   localparam logic [SMOOTH_W-1:0] INC_RESET  = INC_RESET_WIDE[SMOOTH_W-1:0];
   localparam logic [DUTY_W-1:0]   DUTY_RESET = DUTY_W'(64'd1 << 31);
   localparam logic [COEFF_W-1:0]  COEFF_RESET  = COEFF_W'(66);
   localparam logic [VOLUME_W-1:0] VOLUME_RESET = VOLUME_W'(16384);

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SMOOTHING_COEFF = 1'b0,
      CSR_VOLUME          = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

// ===== rtl/pwmosc_pole.sv =====
// ----------------------------------------------------------------------------
// pwmosc_pole: one step of a one-pole smoothing filter
// Moves the state toward the target by floor(|target - state| * k / 2^16),
// truncated toward zero, so the result never passes the target.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwmosc_pole (
   input  wire logic [pwmosc_pkg::SMOOTH_W-1:0] state_value,
   input  wire logic [pwmosc_pkg::SMOOTH_W-1:0] target_value,
   input  wire logic [pwmosc_pkg::COEFF_W-1:0]  coeff,
   output logic      [pwmosc_pkg::SMOOTH_W-1:0] next_value
);

   logic                              rising;
   logic [pwmosc_pkg::SMOOTH_W-1:0]   diff;
   logic [pwmosc_pkg::PROD_W-1:0]     product;
   logic [pwmosc_pkg::SMOOTH_W-1:0]   step;

   // Magnitude of the distance to the target and its direction.
   assign rising = (target_value >= state_value);
   assign diff   = rising ? (target_value - state_value) : (state_value - target_value);

   // Scale the distance by the coefficient, dropping the Q0.16 fraction.
   assign product = pwmosc_pkg::PROD_W'(diff) * pwmosc_pkg::PROD_W'(coeff);
   assign step    = product[pwmosc_pkg::PROD_W-1:pwmosc_pkg::COEFF_W];

   // Apply the step in the direction of the target.
   assign next_value = rising ? (state_value + step) : (state_value - step);

endmodule

`default_nettype wire

// ===== rtl/pwm_oscillator_smoothed_top.sv =====
// ----------------------------------------------------------------------------
// pwm_oscillator_smoothed_top: smoothed phase-accumulator PWM oscillator
// Each request transaction is one sample tick carrying a target increment
// and duty; each response transaction is one pulse-wave sample.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid/req_ready) takes one sample tick per
//   transaction. The response channel (rsp_valid/rsp_ready) returns exactly
//   one sample and level per request, in order.
//   An accepted request first loads the smoothing stage and then moves on
//   into the phase and compare stage, whose registers hold its response.
//   Throughput: one transaction per cycle while rsp_ready is high. The
//   smoothing filters loop through a single 48x16 multiplier each and the
//   phase accumulator through an add, so no loop holds back the next tick.
//   Stalls: when rsp_ready is low the held response stays put and the
//   smoothing stage still takes one more request; req_ready drops only
//   when both stages are full.
//   Reset (synchronous, active high) empties the pipeline, restores the
//   100 Hz increment, a duty of one half, zero phase, coefficient 66 and
//   volume 16384. Configuration writes via csr_wr_en take effect at once
//   and are meant for when the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwm_oscillator_smoothed_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Request channel.
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [pwmosc_pkg::TINC_W-1:0]         req_target_increment,
   input  wire logic [pwmosc_pkg::TDUTY_W-1:0]        req_target_duty,
   // Response channel.
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [pwmosc_pkg::SAMPLE_W-1:0]     rsp_sample,
   output logic                                       rsp_level,
   // Configuration port.
   input  wire logic                                  csr_wr_en,
   input  wire logic [pwmosc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pwmosc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic [pwmosc_pkg::COEFF_W-1:0]    coeff_ff, coeff_in;
   logic [pwmosc_pkg::VOLUME_W-1:0]   volume_ff, volume_in;

   // Smoothed state and phase.
   logic [pwmosc_pkg::SMOOTH_W-1:0]   smooth_inc_ff, smooth_inc_in;
   logic [pwmosc_pkg::DUTY_W-1:0]     smooth_duty_ff, smooth_duty_in;
   logic [pwmosc_pkg::PHASE_W-1:0]    phase_ff, phase_in;

   // Pipeline valid bits and response payload.
   logic                              stage_valid_ff, stage_valid_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [pwmosc_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic                              level_ff, level_in;

   logic                              req_fire;
   logic                              stage_advance;
   logic [pwmosc_pkg::TDUTY_W-1:0]    duty_sat;
   logic [pwmosc_pkg::SMOOTH_W-1:0]   inc_target;
   logic [pwmosc_pkg::SMOOTH_W-1:0]   duty_target;
   logic [pwmosc_pkg::SMOOTH_W-1:0]   duty_state_wide;
   logic [pwmosc_pkg::SMOOTH_W-1:0]   inc_next;
   logic [pwmosc_pkg::SMOOTH_W-1:0]   duty_next;
   logic [pwmosc_pkg::SAMPLE_W-1:0]   volume_ext;

   // Handshake: the smoothing stage moves on when the response slot is free.
   assign stage_advance = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready     = !stage_valid_ff || stage_advance;
   assign req_fire      = req_valid && req_ready;

   // Configuration register decode.
   always_comb begin
      coeff_in  = coeff_ff;
      volume_in = volume_ff;
      if (csr_wr_en) begin
         unique case (pwmosc_pkg::csr_index_type'(csr_index))
            pwmosc_pkg::CSR_SMOOTHING_COEFF: begin
               coeff_in = csr_wdata[pwmosc_pkg::COEFF_W-1:0];
            end
            pwmosc_pkg::CSR_VOLUME: begin
               volume_in = csr_wdata[pwmosc_pkg::VOLUME_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Targets scaled to the smoothed formats, duty saturated at one.
   assign duty_sat = (req_target_duty > pwmosc_pkg::DUTY_ONE) ? pwmosc_pkg::DUTY_ONE
                                                              : req_target_duty;
   assign inc_target  = pwmosc_pkg::SMOOTH_W'({req_target_increment,
                                               pwmosc_pkg::FRAC_EXTRA'(0)});
   assign duty_target = pwmosc_pkg::SMOOTH_W'({duty_sat, pwmosc_pkg::FRAC_EXTRA'(0)});
   assign duty_state_wide = pwmosc_pkg::SMOOTH_W'(smooth_duty_ff);

   // One-pole smoothing of increment and duty.
   pwmosc_pole u_pole_inc (
      .state_value  (smooth_inc_ff),
      .target_value (inc_target),
      .coeff        (coeff_ff),
      .next_value   (inc_next)
   );

   pwmosc_pole u_pole_duty (
      .state_value  (duty_state_wide),
      .target_value (duty_target),
      .coeff        (coeff_ff),
      .next_value   (duty_next)
   );

   // Smoothing stage: state moves on every accepted transaction.
   always_comb begin
      smooth_inc_in  = smooth_inc_ff;
      smooth_duty_in = smooth_duty_ff;
      if (req_fire) begin
         smooth_inc_in  = inc_next;
         smooth_duty_in = duty_next[pwmosc_pkg::DUTY_W-1:0];
      end
      stage_valid_in = req_fire || (stage_valid_ff && !stage_advance);
   end

   // Phase and compare stage: accumulate and form the pulse sample.
   assign volume_ext = pwmosc_pkg::SAMPLE_W'(volume_ff);

   always_comb begin
      phase_in  = phase_ff;
      sample_in = sample_ff;
      level_in  = level_ff;
      if (stage_advance) begin
         phase_in = phase_ff + smooth_inc_ff[pwmosc_pkg::SMOOTH_W-1:pwmosc_pkg::FRAC_EXTRA];
         level_in = (pwmosc_pkg::DUTY_W'(phase_in) < smooth_duty_ff);
         sample_in = level_in ? signed'(volume_ext) : -signed'(volume_ext);
      end
      rsp_valid_in = stage_advance || (rsp_valid_ff && !rsp_ready);
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff       <= pwmosc_pkg::COEFF_RESET;
         volume_ff      <= pwmosc_pkg::VOLUME_RESET;
         smooth_inc_ff  <= pwmosc_pkg::INC_RESET;
         smooth_duty_ff <= pwmosc_pkg::DUTY_RESET;
         phase_ff       <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         coeff_ff       <= coeff_in;
         volume_ff      <= volume_in;
         smooth_inc_ff  <= smooth_inc_in;
         smooth_duty_ff <= smooth_duty_in;
         phase_ff       <= phase_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      level_ff  <= level_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = sample_ff;
   assign rsp_level  = level_ff;

   // The request side stalls only when both stages hold a transaction.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (stage_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request stall without a full pipeline");

   // An accepted request always occupies the smoothing stage next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> stage_valid_ff)
      else $error("accepted request lost from the smoothing stage");

   // The smoothed duty never passes one, since each step stops at the target.
   assert property (@(posedge clock) disable iff (reset)
      smooth_duty_ff <= pwmosc_pkg::DUTY_W'(64'd1 << 32))
      else $error("smoothed duty above one");

   // A fresh response carries the volume with the sign of its level.
   assert property (@(posedge clock) disable iff (reset)
      stage_advance |=> (rsp_level ? (rsp_sample == signed'(volume_ext))
                                   : (rsp_sample == -signed'(volume_ext))))
      else $error("response sample does not match level and volume");

endmodule

`default_nettype wire
